// File: rtl/core/pkm_pkg.sv
// ----------------------------------------------------------------------------
// Keypoint mean distance package
// Shared types, field widths and fixed constants of the keypoint distance block.
// ----------------------------------------------------------------------------
package pkm_pkg;

	localparam int COORD_W   = 16;
	localparam int SIZE_W    = 12;
	localparam int NORM_W    = 17;
	localparam int SQ_W      = 2 * NORM_W;
	localparam int SUM_W     = 21;
	localparam int MEAN_W    = 17;
	localparam int CFG_IDX_W = 1;

	localparam int DIV_STEPS  = NORM_W;
	localparam int ROOT_STEPS = 18;
	localparam int STEP_CNT_W = 5;

	localparam logic [NORM_W-1:0] ONE_Q16  = 17'd65536;
	localparam logic [SUM_W-1:0]  SUM_MAX  = 21'd2097151;
	localparam logic [MEAN_W-1:0] MEAN_MAX = 17'd92682;

	localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 12'd1920;
	localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 12'd1080;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SQUARE,
		ST_ROOT,
		ST_MLOAD,
		ST_MEAN,
		ST_OUT
	} state_t;

endpackage

// File: rtl/core/pkm_keypoint_if.sv
// ----------------------------------------------------------------------------
// Keypoint channel
// Valid/ready channel carrying one detected and one reference keypoint.
// ----------------------------------------------------------------------------
interface pkm_keypoint_if;

	logic                        valid;
	logic                        ready;
	logic [pkm_pkg::COORD_W-1:0] det_x;
	logic [pkm_pkg::COORD_W-1:0] det_y;
	logic [pkm_pkg::COORD_W-1:0] ref_x;
	logic [pkm_pkg::COORD_W-1:0] ref_y;
	logic                        last_point;

	modport source (output valid, det_x, det_y, ref_x, ref_y, last_point, input ready);
	modport sink (input valid, det_x, det_y, ref_x, ref_y, last_point, output ready);

endinterface

// File: rtl/core/pkm_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the mean keypoint distance of one pose pair.
// ----------------------------------------------------------------------------
interface pkm_result_if;

	logic                       valid;
	logic                       ready;
	logic [pkm_pkg::MEAN_W-1:0] mean_distance;

	modport source (output valid, mean_distance, input ready);
	modport sink (input valid, mean_distance, output ready);

endinterface

// File: rtl/core/pkm_div.sv
// ----------------------------------------------------------------------------
// Axis normaliser
// Bit-serial restoring division of a Q12.4 difference by a frame size, giving a
// Q1.16 value that saturates at one.
// ----------------------------------------------------------------------------
module pkm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pkm_pkg::COORD_W-1:0] diff,
	input  logic [pkm_pkg::SIZE_W-1:0]  size,
	output logic [pkm_pkg::NORM_W-1:0]  quot,
	output logic                        done
);

	logic [pkm_pkg::STEP_CNT_W-1:0] cnt_q;
	logic                           done_q;
	logic [pkm_pkg::SIZE_W-1:0]     rem_q;
	logic [pkm_pkg::NORM_W-1:0]     bits_q;
	logic [pkm_pkg::NORM_W-1:0]     quo_q;
	logic                           zero_q;
	logic                           sat_q;
	logic [pkm_pkg::SIZE_W:0]       trial;
	logic                           ge;

	assign trial = {rem_q, bits_q[pkm_pkg::NORM_W-1]};
	assign ge    = trial >= {1'b0, size};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= pkm_pkg::STEP_CNT_W'(pkm_pkg::DIV_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == pkm_pkg::STEP_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, diff[pkm_pkg::COORD_W-1:5]};
			bits_q <= {diff[4:0], 12'd0};
			quo_q  <= '0;
			zero_q <= diff == '0;
			sat_q  <= {1'b0, diff[pkm_pkg::COORD_W-1:5]} >= size;
		end else if (cnt_q != '0) begin
			rem_q  <= ge ? pkm_pkg::SIZE_W'(trial - {1'b0, size}) : trial[pkm_pkg::SIZE_W-1:0];
			bits_q <= {bits_q[pkm_pkg::NORM_W-2:0], 1'b0};
			quo_q  <= {quo_q[pkm_pkg::NORM_W-2:0], ge};
		end
	end

	always_comb begin
		priority if (zero_q) begin
			quot = '0;
		end else if (sat_q || quo_q > pkm_pkg::ONE_Q16) begin
			quot = pkm_pkg::ONE_Q16;
		end else begin
			quot = quo_q;
		end
	end

	assign done = done_q;

endmodule

// File: rtl/core/pkm_sqrt.sv
// ----------------------------------------------------------------------------
// Rounded square root
// Digit-by-digit square root, two radicand bits per cycle, rounded to nearest.
// ----------------------------------------------------------------------------
module pkm_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pkm_pkg::SQ_W-1:0]   val,
	output logic [pkm_pkg::NORM_W-1:0] root,
	output logic                       done
);

	localparam int VW = 2 * pkm_pkg::ROOT_STEPS;
	localparam int RW = pkm_pkg::NORM_W + 1;

	logic [pkm_pkg::STEP_CNT_W-1:0] cnt_q;
	logic                           done_q;
	logic [VW-1:0]                  v_q;
	logic [RW-1:0]                  rem_q;
	logic [pkm_pkg::NORM_W-1:0]     root_q;
	logic [RW+1:0]                  bring;
	logic [RW+1:0]                  trial;
	logic                           ge;

	assign bring = {rem_q, v_q[VW-1:VW-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = bring >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= pkm_pkg::STEP_CNT_W'(pkm_pkg::ROOT_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == pkm_pkg::STEP_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= VW'(val);
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			v_q    <= {v_q[VW-3:0], 2'b00};
			rem_q  <= ge ? RW'(bring - trial) : RW'(bring);
			root_q <= {root_q[pkm_pkg::NORM_W-2:0], ge};
		end
	end

	// Round up when the remainder exceeds the truncated root.
	assign root = root_q + pkm_pkg::NORM_W'(rem_q > {1'b0, root_q});
	assign done = done_q;

endmodule

// File: rtl/core/pose_keypoint_mean_distance.sv
// ----------------------------------------------------------------------------
// Pose keypoint mean distance
// Accumulates normalised keypoint distances and emits their mean per pose pair.
// ----------------------------------------------------------------------------
// A kept keypoint runs, after its transfer, through the bit-serial axis dividers, the squares,
// the load of the root unit, the root and the accumulation before the next one is accepted.
// A skipped keypoint is taken without these steps.
// A last keypoint adds the bit-serial division by the keypoint count
// and the output register load.
// Reset clears the accumulator and the control state and sets the frame size.
module pose_keypoint_mean_distance #(
	parameter int KEYPOINT_COUNT = 18
) (
	input  logic                             clk,
	input  logic                             arst_n,
	pkm_keypoint_if.sink                     keypoint,
	pkm_result_if.source                     result,
	input  logic                             cfg_we,
	input  logic [pkm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pkm_pkg::SIZE_W-1:0]       cfg_data
);

	localparam int NW  = pkm_pkg::SUM_W + 1;
	localparam int RW  = $clog2(KEYPOINT_COUNT + 1);
	localparam int MCW = $clog2(NW + 1);
	localparam logic [NW-1:0] HalfK   = NW'(KEYPOINT_COUNT / 2);
	localparam logic [RW:0]   Divisor = (RW + 1)'(KEYPOINT_COUNT);

	pkm_pkg::state_t state_q, state_nx;

	logic [pkm_pkg::SIZE_W-1:0]  width_q;
	logic [pkm_pkg::SIZE_W-1:0]  height_q;
	logic                        last_q;
	logic [pkm_pkg::SUM_W-1:0]   sum_q;
	logic [pkm_pkg::SQ_W-1:0]    sqx_s1;
	logic [pkm_pkg::SQ_W-1:0]    sqy_s1;
	logic [NW-1:0]               mnum_q;
	logic [RW-1:0]               mrem_q;
	logic [MCW-1:0]              mcnt_q;
	logic                        res_valid_q;
	logic [pkm_pkg::MEAN_W-1:0]  res_data_q;

	logic                        accept;
	logic                        kept;
	logic [pkm_pkg::COORD_W-1:0] diff_x;
	logic [pkm_pkg::COORD_W-1:0] diff_y;
	logic [pkm_pkg::NORM_W-1:0]  norm_x;
	logic [pkm_pkg::NORM_W-1:0]  norm_y;
	logic                        div_x_done;
	logic                        div_y_done;
	logic [pkm_pkg::NORM_W-1:0]  root;
	logic                        root_done;
	logic [pkm_pkg::SUM_W:0]     sum_add;
	logic [RW:0]                 mtrial;
	logic                        mge;
	logic [pkm_pkg::MEAN_W-1:0]  mean_sat;

	logic                        in_ready;
	logic                        div_start;
	logic                        sqrt_start;
	logic                        acc_en;
	logic                        mload_en;
	logic                        mstep_en;
	logic                        out_load;

	assign accept = keypoint.valid && in_ready;
	assign kept   = keypoint.det_x != '0 && keypoint.det_y != '0 &&
		keypoint.ref_x != '0 && keypoint.ref_y != '0;
	assign diff_x = (keypoint.det_x > keypoint.ref_x) ? keypoint.det_x - keypoint.ref_x
		: keypoint.ref_x - keypoint.det_x;
	assign diff_y = (keypoint.det_y > keypoint.ref_y) ? keypoint.det_y - keypoint.ref_y
		: keypoint.ref_y - keypoint.det_y;

	pkm_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.diff   (diff_x),
		.size   (width_q),
		.quot   (norm_x),
		.done   (div_x_done)
	);

	pkm_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.diff   (diff_y),
		.size   (height_q),
		.quot   (norm_y),
		.done   (div_y_done)
	);

	pkm_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.val    (sqx_s1 + sqy_s1),
		.root   (root),
		.done   (root_done)
	);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			pkm_pkg::ST_IDLE: begin
				if (keypoint.valid) begin
					if (kept) begin
						state_nx = pkm_pkg::ST_DIV;
					end else if (keypoint.last_point) begin
						state_nx = pkm_pkg::ST_MLOAD;
					end
				end
			end
			pkm_pkg::ST_DIV: begin
				if (div_x_done) begin
					state_nx = pkm_pkg::ST_SQUARE;
				end
			end
			pkm_pkg::ST_SQUARE: state_nx = pkm_pkg::ST_ROOT;
			pkm_pkg::ST_ROOT: begin
				if (root_done) begin
					state_nx = last_q ? pkm_pkg::ST_MLOAD : pkm_pkg::ST_IDLE;
				end
			end
			pkm_pkg::ST_MLOAD: state_nx = pkm_pkg::ST_MEAN;
			pkm_pkg::ST_MEAN: begin
				if (mcnt_q == MCW'(1)) begin
					state_nx = pkm_pkg::ST_OUT;
				end
			end
			pkm_pkg::ST_OUT: begin
				if (!res_valid_q || result.ready) begin
					state_nx = pkm_pkg::ST_IDLE;
				end
			end
			default: state_nx = pkm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = state_q == pkm_pkg::ST_IDLE;
		div_start  = in_ready && keypoint.valid && kept;
		sqrt_start = state_q == pkm_pkg::ST_SQUARE;
		acc_en     = state_q == pkm_pkg::ST_ROOT && root_done;
		mload_en   = state_q == pkm_pkg::ST_MLOAD;
		mstep_en   = state_q == pkm_pkg::ST_MEAN;
		out_load   = state_q == pkm_pkg::ST_OUT && (!res_valid_q || result.ready);
	end

	assign sum_add  = {1'b0, sum_q} + (pkm_pkg::SUM_W + 1)'(root);
	assign mtrial   = {mrem_q, mnum_q[NW-1]};
	assign mge      = mtrial >= Divisor;
	assign mean_sat = (mnum_q > NW'(pkm_pkg::MEAN_MAX)) ? pkm_pkg::MEAN_MAX
		: mnum_q[pkm_pkg::MEAN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pkm_pkg::ST_IDLE;
			width_q     <= pkm_pkg::FRAME_WIDTH_RST;
			height_q    <= pkm_pkg::FRAME_HEIGHT_RST;
			last_q      <= 1'b0;
			sum_q       <= '0;
			mcnt_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				unique case (cfg_index)
					pkm_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data;
					pkm_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				last_q <= keypoint.last_point;
			end
			if (acc_en) begin
				sum_q <= sum_add[pkm_pkg::SUM_W] ? pkm_pkg::SUM_MAX : sum_add[pkm_pkg::SUM_W-1:0];
			end else if (mload_en) begin
				sum_q <= '0;
			end
			if (mload_en) begin
				mcnt_q <= MCW'(NW);
			end else if (mstep_en) begin
				mcnt_q <= mcnt_q - 1'b1;
			end
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_x_done) begin
			sqx_s1 <= pkm_pkg::SQ_W'(norm_x) * pkm_pkg::SQ_W'(norm_x);
			sqy_s1 <= pkm_pkg::SQ_W'(norm_y) * pkm_pkg::SQ_W'(norm_y);
		end
		if (mload_en) begin
			mnum_q <= {1'b0, sum_q} + HalfK;
			mrem_q <= '0;
		end else if (mstep_en) begin
			mnum_q <= {mnum_q[NW-2:0], mge};
			mrem_q <= mge ? RW'(mtrial - Divisor) : mtrial[RW-1:0];
		end
		if (out_load) begin
			res_data_q <= mean_sat;
		end
	end

	assign keypoint.ready       = in_ready;
	assign result.valid         = res_valid_q;
	assign result.mean_distance = res_data_q;

	// Both axis dividers are started together and must finish together.
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		div_x_done == div_y_done)
		else $error("axis dividers out of step");

	a_root_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> state_q == pkm_pkg::ST_ROOT)
		else $error("root finished outside the root state");

	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> res_data_q <= pkm_pkg::MEAN_MAX)
		else $error("mean above saturation limit");

	a_out_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pkm_pkg::ST_OUT && res_valid_q && !result.ready
		|=> state_q == pkm_pkg::ST_OUT && res_valid_q)
		else $error("pending result overwritten");

endmodule
